// ===== rtl/rlp_tlid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlp_tlid_pkg
// Shared types and constants of the RLP top-level item decoder.
// ----------------------------------------------------------------------------
package rlp_tlid_pkg;

	localparam int unsigned POSITION_BITS_DEF    = 32;
	localparam int unsigned MAX_LENGTH_BYTES_DEF = 8;

	localparam logic [7:0] HDR_SHORT_STR  = 8'h80;
	localparam logic [7:0] HDR_LONG_STR   = 8'hb8;
	localparam logic [7:0] HDR_SHORT_LIST = 8'hc0;
	localparam logic [7:0] HDR_LONG_LIST  = 8'hf8;
	localparam logic [7:0] LONG_STR_BASE  = 8'hb7;
	localparam logic [7:0] LONG_LIST_BASE = 8'hf7;

	typedef enum logic [3:0] {
		PH_HEADER  = 4'b0001,
		PH_LENGTH  = 4'b0010,
		PH_PAYLOAD = 4'b0100,
		PH_DONE    = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		ST_STRING   = 3'd0,
		ST_LIST     = 3'd1,
		ST_RANGE    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_COUNT    = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic        last_byte;
		logic [31:0] target_index;
		logic        count_mode;
	} in_word_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] payload_offset;
		logic [31:0] payload_length;
		logic [31:0] item_count;
		logic [63:0] uint_value;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/rlp_tlid_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlp_tlid_in_stage
// Input register: captures one byte word and holds it until the walker
// takes it.
// ----------------------------------------------------------------------------
module rlp_tlid_in_stage (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire rlp_tlid_pkg::in_word_t in_word,
	output logic                        in_ready,
	input  wire logic                   advance,
	output logic                        valid_s1,
	output rlp_tlid_pkg::in_word_t      word_s1
);
	import rlp_tlid_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rlp_tlid_walker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlp_tlid_walker
// Per-byte parse state: decodes headers and length bytes, skips payloads,
// tracks the selected item and forms the result on the buffer's last byte.
// ----------------------------------------------------------------------------
module rlp_tlid_walker #(
	parameter int unsigned POSITION_BITS    = rlp_tlid_pkg::POSITION_BITS_DEF,
	parameter int unsigned MAX_LENGTH_BYTES = rlp_tlid_pkg::MAX_LENGTH_BYTES_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   take,
	input  wire rlp_tlid_pkg::in_word_t word,
	output logic                        res_valid,
	output rlp_tlid_pkg::result_t       res
);
	import rlp_tlid_pkg::*;

	localparam int unsigned PB    = POSITION_BITS;
	localparam int unsigned LEN_W = 8 * MAX_LENGTH_BYTES;
	localparam int unsigned CMP_W = (LEN_W > PB + 1) ? LEN_W : PB + 1;

	phase_t            phase_q, phase_n;
	logic [PB-1:0]     pos_q, pos_n;
	logic [31:0]       cnt_q, cnt_n;
	logic [3:0]        lbl_q, lbl_n;
	logic [LEN_W-1:0]  lacc_q, lacc_n;
	logic [PB-1:0]     pleft_q, pleft_n;
	logic              found_q, found_n;
	logic              list_q, list_n;
	logic [PB:0]       moff_q, moff_n;
	logic [PB-1:0]     mlen_q, mlen_n;
	logic [63:0]       val_q, val_n;
	logic [31:0]       hidx_q, hidx_n;
	logic              hcnt_q, hcnt_n;
	logic              err_q, err_n;

	always_comb begin
		logic [7:0]       b;
		logic             is_target;
		logic             open_req;
		logic [LEN_W-1:0] open_len;
		logic [PB:0]      offset;
		logic [PB:0]      room;
		logic [7:0]       n_len;
		logic [7:0]       short_len;

		b         = word.byte_value;
		phase_n   = phase_q;
		pos_n     = pos_q;
		cnt_n     = cnt_q;
		lbl_n     = lbl_q;
		lacc_n    = lacc_q;
		pleft_n   = pleft_q;
		found_n   = found_q;
		list_n    = list_q;
		moff_n    = moff_q;
		mlen_n    = mlen_q;
		val_n     = val_q;
		hidx_n    = hidx_q;
		hcnt_n    = hcnt_q;
		err_n     = err_q;
		open_req  = 1'b0;
		open_len  = '0;
		n_len     = '0;
		short_len = '0;

		// sample selection on the buffer's first byte
		if (pos_q == '0) begin
			hidx_n = word.target_index;
			hcnt_n = word.count_mode;
		end
		is_target = !hcnt_n && (cnt_q == hidx_n);

		unique case (phase_q)
			PH_HEADER: begin
				if (b < HDR_SHORT_STR) begin
					if (is_target) begin
						found_n = 1'b1;
						list_n  = 1'b0;
						moff_n  = {1'b0, pos_q};
						mlen_n  = PB'(1);
						val_n   = 64'(b);
						phase_n = PH_DONE;
					end else begin
						cnt_n = cnt_q + 32'd1;
					end
				end else if (b < HDR_LONG_STR || (b >= HDR_SHORT_LIST && b < HDR_LONG_LIST)) begin
					list_n    = (b >= HDR_SHORT_LIST);
					short_len = b - (list_n ? HDR_SHORT_LIST : HDR_SHORT_STR);
					open_req  = 1'b1;
					open_len  = LEN_W'(short_len);
				end else begin
					list_n = (b >= HDR_LONG_LIST);
					n_len  = b - (list_n ? LONG_LIST_BASE : LONG_STR_BASE);
					if (n_len > 8'(MAX_LENGTH_BYTES)) begin
						err_n   = 1'b1;
						phase_n = PH_DONE;
					end else begin
						lbl_n   = n_len[3:0];
						lacc_n  = '0;
						phase_n = PH_LENGTH;
					end
				end
			end
			PH_LENGTH: begin
				lacc_n = (lacc_q << 8) | LEN_W'(b);
				lbl_n  = lbl_q - 4'd1;
				if (lbl_n == 4'd0) begin
					open_req = 1'b1;
					open_len = lacc_n;
				end
			end
			PH_PAYLOAD: begin
				if (found_q) begin
					val_n = {val_q[55:0], b};
				end
				pleft_n = pleft_q - PB'(1);
				if (pleft_n == '0) begin
					phase_n = found_q ? PH_DONE : PH_HEADER;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		// payload length known: range check, then select or skip
		offset = {1'b0, pos_q} + (PB + 1)'(1);
		room   = {1'b1, {PB{1'b0}}} - offset;
		if (open_req) begin
			if (CMP_W'(open_len) > CMP_W'(room)) begin
				err_n   = 1'b1;
				phase_n = PH_DONE;
			end else if (is_target) begin
				found_n = 1'b1;
				moff_n  = offset;
				mlen_n  = PB'(open_len);
				val_n   = '0;
				pleft_n = PB'(open_len);
				phase_n = (open_len == '0) ? PH_DONE : PH_PAYLOAD;
			end else begin
				cnt_n   = cnt_q + 32'd1;
				pleft_n = PB'(open_len);
				phase_n = (open_len == '0) ? PH_HEADER : PH_PAYLOAD;
			end
		end

		if (!word.last_byte) begin
			if (pos_q == '1) begin
				if (phase_n != PH_DONE) begin
					err_n   = 1'b1;
					phase_n = PH_DONE;
				end
			end else begin
				pos_n = pos_q + PB'(1);
			end
		end

		res = '0;
		if (err_n) begin
			res.status = ST_RANGE;
		end else if (hcnt_n) begin
			if (phase_n == PH_HEADER) begin
				res.status     = ST_COUNT;
				res.item_count = cnt_n;
			end else begin
				res.status = ST_RANGE;
			end
		end else if (phase_n == PH_DONE && found_n) begin
			res.status         = list_n ? ST_LIST : ST_STRING;
			res.payload_offset = 32'(moff_n);
			res.payload_length = 32'(mlen_n);
			if (!list_n && mlen_n != '0 && mlen_n <= PB'(8)) begin
				res.uint_value = val_n;
			end
		end else if (phase_n == PH_HEADER) begin
			res.status = ST_NOTFOUND;
		end else begin
			res.status = ST_RANGE;
		end
	end

	assign res_valid = take && word.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			cnt_q   <= '0;
			lbl_q   <= '0;
			lacc_q  <= '0;
			pleft_q <= '0;
			found_q <= 1'b0;
			list_q  <= 1'b0;
			moff_q  <= '0;
			mlen_q  <= '0;
			val_q   <= '0;
			hidx_q  <= '0;
			hcnt_q  <= 1'b0;
			err_q   <= 1'b0;
		end else if (take) begin
			if (word.last_byte) begin
				phase_q <= PH_HEADER;
				pos_q   <= '0;
				cnt_q   <= '0;
				lbl_q   <= '0;
				lacc_q  <= '0;
				pleft_q <= '0;
				found_q <= 1'b0;
				list_q  <= 1'b0;
				moff_q  <= '0;
				mlen_q  <= '0;
				val_q   <= '0;
				hidx_q  <= '0;
				hcnt_q  <= 1'b0;
				err_q   <= 1'b0;
			end else begin
				phase_q <= phase_n;
				pos_q   <= pos_n;
				cnt_q   <= cnt_n;
				lbl_q   <= lbl_n;
				lacc_q  <= lacc_n;
				pleft_q <= pleft_n;
				found_q <= found_n;
				list_q  <= list_n;
				moff_q  <= moff_n;
				mlen_q  <= mlen_n;
				val_q   <= val_n;
				hidx_q  <= hidx_n;
				hcnt_q  <= hcnt_n;
				err_q   <= err_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rlp_tlid_out_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlp_tlid_out_stage
// Result register: holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module rlp_tlid_out_stage (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  res_valid,
	input  wire rlp_tlid_pkg::result_t res,
	output logic                       can_take,
	input  wire logic                  out_ready,
	output logic                       valid_s2,
	output rlp_tlid_pkg::result_t      res_s2
);
	import rlp_tlid_pkg::*;

	assign can_take = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res_valid) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_s2 <= res;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rlp_top_level_item_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rlp_top_level_item_decoder
// RLP top-level item decoder: finds one top-level item or counts them.
// ----------------------------------------------------------------------------
// Takes one buffer byte per cycle unless the input side stalls. Each word
// passes an input register, then the walker updates its parse state; a result
// word is formed only for the byte marked last, combinationally from the input
// register, and reaches the master side through the result register. The input
// side stalls only when a last byte is pending and the result register still
// holds an untaken result. Status codes: 0 string, 1 list, 2 out_of_range, 3 not_found, 4 count.
module rlp_top_level_item_decoder #(
	parameter int unsigned POSITION_BITS    = rlp_tlid_pkg::POSITION_BITS_DEF,
	parameter int unsigned MAX_LENGTH_BYTES = rlp_tlid_pkg::MAX_LENGTH_BYTES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [39:0]  s_tdata,  // byte_value, target_index
	input  wire logic         s_tlast,
	input  wire logic         s_tuser,  // count_mode
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [159:0]      m_tdata,  // payload_offset, payload_length, item_count, uint_value
	output logic [2:0]        m_tuser   // status
);
	import rlp_tlid_pkg::*;

	in_word_t in_word;
	in_word_t word_s1;
	logic     valid_s1;
	logic     advance;
	logic     take;
	logic     can_take;
	logic     res_valid;
	result_t  res;
	result_t  res_s2;

	always_comb begin
		in_word.byte_value   = s_tdata[7:0];
		in_word.target_index = s_tdata[39:8];
		in_word.last_byte    = s_tlast;
		in_word.count_mode   = s_tuser;
	end

	assign advance = !word_s1.last_byte || can_take;
	assign take    = valid_s1 && advance;

	rlp_tlid_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_word  (in_word),
		.in_ready (s_tready),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	rlp_tlid_walker #(
		.POSITION_BITS    (POSITION_BITS),
		.MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.word      (word_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	rlp_tlid_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.can_take  (can_take),
		.out_ready (m_tready),
		.valid_s2  (m_tvalid),
		.res_s2    (res_s2)
	);

	assign m_tdata = {res_s2.uint_value, res_s2.item_count,
	                  res_s2.payload_length, res_s2.payload_offset};
	assign m_tuser = res_s2.status;

	a_last_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && word_s1.last_byte && m_tvalid && !m_tready |=> valid_s1)
		else $error("last byte dropped while result register full");

	a_count_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_COUNT |-> m_tdata[95:64] == 32'd0)
		else $error("item count set outside count status");

	a_no_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_RANGE || m_tuser == ST_NOTFOUND)
		|-> m_tdata[63:0] == 64'd0 && m_tdata[159:96] == 64'd0)
		else $error("item fields set without a found item");

endmodule
`default_nettype wire
